>>> design/ffra_pkg.sv
`default_nettype none

package ffra_pkg;

  localparam int BASE_W = 16;
  localparam int LEN_W  = 17;
  localparam int CAND_W = 18;

  localparam logic OP_ALLOC   = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  localparam logic [1:0] ST_ALLOC   = 2'd0;
  localparam logic [1:0] ST_NOSPACE = 2'd1;
  localparam logic [1:0] ST_RELEASE = 2'd2;

  typedef struct packed {
    logic              operation;
    logic [2:0]        slot;
    logic [LEN_W-1:0]  length;
  } in_item_t;

  typedef struct packed {
    logic [BASE_W-1:0] base_address;
    logic [1:0]        status;
    logic              table_empty;
  } out_item_t;

  typedef struct packed {
    logic [BASE_W-1:0] base;
    logic [LEN_W-1:0]  length;
  } entry_t;

  typedef struct packed {
    logic load;
    logic cand_low;
    logic cand_issue;
    logic cand_load;
    logic cand_next;
    logic scan_start;
    logic scan_step;
    logic accept;
    logic respond;
  } dp_cmd_t;

  typedef struct packed {
    logic is_release;
    logic slot_ok;
    logic cand_is_low;
    logic cand_live;
    logic cand_done;
    logic pre_pass;
    logic len_zero;
    logic scan_done;
    logic scan_clear;
  } dp_sts_t;

endpackage

`default_nettype wire

>>> design/ffra_ram.sv
`default_nettype none

module ffra_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  wire logic                                     clk,
  input  wire logic                                     we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                         wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> design/ffra_ctrl.sv
`default_nettype none

module ffra_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire ffra_pkg::dp_sts_t sts,
  output ffra_pkg::dp_cmd_t      cmd
);
  import ffra_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_DISP  = 7'b0000010,
    S_CAND  = 7'b0000100,
    S_CLOAD = 7'b0001000,
    S_PRE   = 7'b0010000,
    S_SCAN  = 7'b0100000,
    S_RESP  = 7'b1000000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        if (sts.is_release || !sts.slot_ok) begin
          state_nxt = S_RESP;
        end else begin
          state_nxt = S_CAND;
        end
      end
      S_CAND: begin
        priority if (sts.cand_done) begin
          state_nxt = S_RESP;
        end else if (sts.cand_is_low) begin
          cmd.cand_low = 1'b1;
          state_nxt    = S_PRE;
        end else if (sts.cand_live) begin
          cmd.cand_issue = 1'b1;
          state_nxt      = S_CLOAD;
        end else begin
          cmd.cand_next = 1'b1;
        end
      end
      S_CLOAD: begin
        cmd.cand_load = 1'b1;
        state_nxt     = S_PRE;
      end
      S_PRE: begin
        priority if (!sts.pre_pass) begin
          cmd.cand_next = 1'b1;
          state_nxt     = S_CAND;
        end else if (sts.len_zero) begin
          cmd.accept    = 1'b1;
          cmd.cand_next = 1'b1;
          state_nxt     = S_CAND;
        end else begin
          cmd.scan_start = 1'b1;
          state_nxt      = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_done) begin
          cmd.accept    = sts.scan_clear;
          cmd.cand_next = 1'b1;
          state_nxt     = S_CAND;
        end
      end
      S_RESP: begin
        cmd.respond = 1'b1;
        state_nxt   = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

`default_nettype wire

>>> design/ffra_dp.sv
`default_nettype none

module ffra_dp #(
  parameter int SLOTS          = 8,
  parameter int MEM_BYTES      = 65536,
  parameter int RESERVED_BASE  = 0,
  parameter int RESERVED_BYTES = 256
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire ffra_pkg::in_item_t  in_item,
  input  wire ffra_pkg::dp_cmd_t   cmd,
  output ffra_pkg::dp_sts_t        sts,
  output logic                     out_valid,
  output ffra_pkg::out_item_t      out_item
);
  import ffra_pkg::*;

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W = $clog2(SLOTS + 2);
  localparam int MEM_W = $clog2(MEM_BYTES + 1);
  localparam int CMP_W = (MEM_W > CAND_W + 1) ? MEM_W : CAND_W + 1;
  localparam logic [CAND_W-1:0] LOWEST  = CAND_W'(RESERVED_BASE + RESERVED_BYTES);
  localparam logic [CMP_W-1:0]  MEM_LIM = CMP_W'(MEM_BYTES);
  localparam logic [CAND_W-1:0] BASE_MAX = CAND_W'({BASE_W{1'b1}});

  in_item_t          req_r;
  logic [SLOTS-1:0]  valid_r;
  logic [SLOTS-1:0]  valid_nxt;
  logic [CNT_W-1:0]  cand_k_r;
  logic [CNT_W-1:0]  scan_cnt_r;
  logic [CAND_W-1:0] cand_r;
  logic [BASE_W-1:0] best_r;
  logic              found_r;
  logic              overlap_r;
  logic              chk_vld_r;
  logic              out_valid_r;
  out_item_t         out_item_r;

  logic [IDX_W-1:0]  slot_idx;
  logic [CNT_W-1:0]  cand_m1;
  logic [IDX_W-1:0]  cand_idx;
  logic [IDX_W-1:0]  scan_idx;
  logic [IDX_W-1:0]  raddr;
  logic [$bits(entry_t)-1:0] rdata;
  entry_t            rd_ent;
  entry_t            wr_ent;
  logic              we;
  logic              slot_ok;
  logic              is_alloc;
  logic [CAND_W-1:0] e_sum;
  logic [CAND_W-1:0] c_end;
  logic [CMP_W-1:0]  c_ext;
  logic [CMP_W-1:0]  fit_end;
  logic              hit;

  assign slot_idx = IDX_W'(req_r.slot);
  assign slot_ok  = (int'(req_r.slot) < SLOTS);
  assign is_alloc = (req_r.operation == OP_ALLOC);
  assign cand_m1  = cand_k_r - CNT_W'(1);
  assign cand_idx = cand_m1[IDX_W-1:0];
  assign scan_idx = scan_cnt_r[IDX_W-1:0];
  assign raddr    = cmd.cand_issue ? cand_idx : scan_idx;

  assign rd_ent  = entry_t'(rdata);
  assign e_sum   = CAND_W'(rd_ent.base) + CAND_W'(rd_ent.length);
  assign c_end   = cand_r + CAND_W'(req_r.length) - CAND_W'(1);
  assign hit     = chk_vld_r && (cand_r <= e_sum) && (CAND_W'(rd_ent.base) <= c_end);
  assign c_ext   = CMP_W'(cand_r);
  assign fit_end = c_ext + CMP_W'(req_r.length);

  assign we            = cmd.respond && is_alloc && found_r;
  assign wr_ent.base   = best_r;
  assign wr_ent.length = req_r.length;

  ffra_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (slot_idx),
    .wdata (wr_ent),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    sts.is_release  = (req_r.operation == OP_RELEASE);
    sts.slot_ok     = slot_ok;
    sts.cand_is_low = (cand_k_r == '0);
    sts.cand_live   = valid_r[cand_idx];
    sts.cand_done   = (int'(cand_k_r) == SLOTS + 1);
    sts.pre_pass    = (cand_r >= LOWEST)
                   && (!found_r || (cand_r < CAND_W'(best_r)))
                   && (cand_r <= BASE_MAX)
                   && (c_ext < MEM_LIM)
                   && (fit_end <= MEM_LIM);
    sts.len_zero    = (req_r.length == '0);
    sts.scan_done   = (int'(scan_cnt_r) == SLOTS);
    sts.scan_clear  = !(overlap_r || hit);
  end

  always_comb begin
    valid_nxt = valid_r;
    if (cmd.respond && slot_ok) begin
      if (!is_alloc) begin
        valid_nxt[slot_idx] = 1'b0;
      end else if (found_r) begin
        valid_nxt[slot_idx] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r    <= in_item;
      found_r  <= 1'b0;
      cand_k_r <= '0;
    end
    if (cmd.cand_low) begin
      cand_r <= LOWEST;
    end
    if (cmd.cand_load) begin
      cand_r <= e_sum + CAND_W'(1);
    end
    if (cmd.cand_next) begin
      cand_k_r <= cand_k_r + CNT_W'(1);
    end
    if (cmd.scan_start) begin
      scan_cnt_r <= '0;
      overlap_r  <= 1'b0;
      chk_vld_r  <= 1'b0;
    end
    if (cmd.scan_step) begin
      scan_cnt_r <= scan_cnt_r + CNT_W'(1);
      overlap_r  <= overlap_r | hit;
      chk_vld_r  <= (int'(scan_cnt_r) < SLOTS) && valid_r[scan_idx];
    end
    if (cmd.accept) begin
      found_r <= 1'b1;
      best_r  <= cand_r[BASE_W-1:0];
    end
    if (cmd.respond) begin
      out_item_r.table_empty <= (valid_nxt == '0);
      if (!is_alloc) begin
        out_item_r.base_address <= '0;
        out_item_r.status       <= ST_RELEASE;
      end else if (found_r) begin
        out_item_r.base_address <= best_r;
        out_item_r.status       <= ST_ALLOC;
      end else begin
        out_item_r.base_address <= '0;
        out_item_r.status       <= ST_NOSPACE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      valid_r     <= valid_nxt;
      out_valid_r <= cmd.respond;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

`default_nettype wire

>>> design/first_fit_region_allocator.sv
// a release answers without a table sweep; an allocate is bounded by the single read
// port of the region table, swept at most once per candidate start that passes the pre-check
// one request at a time: busy stays high from the accepting edge until the result beat
// result beat is a one-cycle out_valid strobe; the receiver cannot stall
// reset: synchronous active-low, clears all slot valid marks and the controller
`default_nettype none

module first_fit_region_allocator #(
  parameter int SLOTS          = 8,
  parameter int MEM_BYTES      = 65536,
  parameter int RESERVED_BASE  = 0,
  parameter int RESERVED_BYTES = 256
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire ffra_pkg::in_item_t  in_item,
  output logic                     out_valid,
  output ffra_pkg::out_item_t      out_item
);
  import ffra_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  ffra_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  ffra_dp #(
    .SLOTS          (SLOTS),
    .MEM_BYTES      (MEM_BYTES),
    .RESERVED_BASE  (RESERVED_BASE),
    .RESERVED_BYTES (RESERVED_BYTES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire

>>> design/ffra_chk.sv
`default_nettype none

module ffra_chk (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                start,
  input wire logic                busy,
  input wire logic                out_valid,
  input wire ffra_pkg::out_item_t out_item
);
  import ffra_pkg::*;

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted beat did not occupy the block");

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result beat while still busy");

  a_fall_result: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $fell(busy) |-> out_valid)
    else $error("busy dropped without a result beat");

  a_one_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_alloc_base: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item.status == ST_ALLOC) |-> (out_item.base_address != '0))
    else $error("allocation returned base zero");

endmodule

bind first_fit_region_allocator ffra_chk u_chk (.*);

`default_nettype wire
